>>> hw/rtl/etl_pkg.sv
package etl_pkg;

  localparam int unsigned TokW   = 13;
  localparam int unsigned MaxRes = 4;
  localparam int unsigned SlotW  = 2;
  localparam int unsigned CntW   = 3;

  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7a;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChCaret  = 8'h5e;
  localparam logic [7:0] ChSpace  = 8'h20;

  localparam logic [7:0] SqrtText [4] = '{8'h73, 8'h71, 8'h72, 8'h74};
  localparam logic [CntW-1:0] SqrtLen = 3'd4;

  typedef enum logic [3:0] {
    TkNumber = 4'd0,
    TkSqrt   = 4'd1,
    TkLparen = 4'd2,
    TkRparen = 4'd3,
    TkPlus   = 4'd4,
    TkMinus  = 4'd5,
    TkMul    = 4'd6,
    TkDiv    = 4'd7,
    TkPower  = 4'd8,
    TkEnd    = 4'd9,
    TkError  = 4'd10
  } token_kind_e;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrIdent  = 2'd1,
    ErrSymbol = 2'd2,
    ErrLong   = 2'd3
  } err_kind_e;

  typedef struct packed {
    token_kind_e     kind;
    logic [TokW-1:0] start;
    logic [TokW-1:0] length;
    err_kind_e       err;
  } result_t;

  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [CntW-1:0]      count;
  } bundle_t;

endpackage

>>> hw/rtl/etl_if.sv
interface etl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_present;
  logic       expr_end;

  modport source (output valid, char_code, char_present, expr_end, input ready);
  modport sink (input valid, char_code, char_present, expr_end, output ready);
endinterface

interface etl_token_if import etl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [3:0]      token_kind;
  logic [TokW-1:0] token_start;
  logic [TokW-1:0] token_length;
  logic [1:0]      error_kind;
  logic            last_of_item;

  modport source (output valid, token_kind, token_start, token_length, error_kind,
                  last_of_item, input ready);
  modport sink (input valid, token_kind, token_start, token_length, error_kind,
                last_of_item, output ready);
endinterface

>>> hw/rtl/etl_front.sv
module etl_front import etl_pkg::*; #(
  parameter int unsigned MaxLen = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  etl_char_if.sink   chars_i,
  input  logic       full_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  localparam int unsigned PosW = $clog2(MaxLen + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic            in_num_q, in_num_d;
  logic [PosW-1:0] num_start_q, num_start_d;
  logic            in_word_q, in_word_d;
  logic [PosW-1:0] word_start_q, word_start_d;
  logic [CntW-1:0] match_q, match_d;
  logic            mismatch_q, mismatch_d;
  logic            discard_q, discard_d;
  logic            accept;

  function automatic result_t mk_res(token_kind_e kind, logic [PosW-1:0] start,
                                     logic [PosW-1:0] length, err_kind_e err);
    result_t r;
    r.kind   = kind;
    r.start  = TokW'(start);
    r.length = TokW'(length);
    r.err    = err;
    return r;
  endfunction

  assign chars_i.ready = !full_i;
  assign accept        = chars_i.valid && !full_i;

  always_comb begin
    logic [7:0]      c;
    logic            digit;
    logic            alpha;
    logic            err;
    logic            is_tok;
    logic            done;
    token_kind_e     kind;
    logic [CntW-1:0] n;
    logic [PosW-1:0] pos;

    c            = chars_i.char_code;
    digit        = ((c >= ChZero) && (c <= ChNine)) || (c == ChDot);
    alpha        = (c >= ChLowA) && (c <= ChLowZ);
    err          = 1'b0;
    is_tok       = 1'b1;
    done         = 1'b0;
    kind         = TkNumber;
    n            = '0;
    pos          = pos_q;
    pos_d        = pos_q;
    in_num_d     = in_num_q;
    num_start_d  = num_start_q;
    in_word_d    = in_word_q;
    word_start_d = word_start_q;
    match_d      = match_q;
    mismatch_d   = mismatch_q;
    discard_d    = discard_q;
    bundle_o     = '0;

    if (discard_q) begin
      done = chars_i.expr_end;
    end else begin
      if (chars_i.char_present) begin
        if (pos >= PosW'(MaxLen)) begin
          bundle_o.res[n[SlotW-1:0]] = mk_res(TkError, pos, '0, ErrLong);
          n   = n + 1'b1;
          err = 1'b1;
        end else begin
          pos_d = pos + 1'b1;
          if (digit || alpha) begin
            if (digit && !in_num_d) begin
              in_num_d    = 1'b1;
              num_start_d = pos;
            end
            if (alpha && !in_word_d) begin
              in_word_d    = 1'b1;
              word_start_d = pos;
              match_d      = '0;
              mismatch_d   = 1'b0;
            end
            if (in_word_d) begin
              if (match_d < SqrtLen && c == SqrtText[match_d[1:0]]) begin
                match_d = match_d + 1'b1;
              end else begin
                mismatch_d = 1'b1;
              end
            end
          end else begin
            if (in_num_d) begin
              bundle_o.res[n[SlotW-1:0]] =
                mk_res(TkNumber, num_start_d, pos - num_start_d, ErrNone);
              n        = n + 1'b1;
              in_num_d = 1'b0;
            end
            if (in_word_d) begin
              in_word_d = 1'b0;
              if (!mismatch_d && match_d == SqrtLen) begin
                bundle_o.res[n[SlotW-1:0]] =
                  mk_res(TkSqrt, word_start_d, pos - word_start_d, ErrNone);
              end else begin
                bundle_o.res[n[SlotW-1:0]] = mk_res(TkError, word_start_d, '0, ErrIdent);
                err = 1'b1;
              end
              n = n + 1'b1;
            end
            if (!err) begin
              case (c)
                ChLparen: kind = TkLparen;
                ChRparen: kind = TkRparen;
                ChPlus:   kind = TkPlus;
                ChMinus:  kind = TkMinus;
                ChStar:   kind = TkMul;
                ChSlash:  kind = TkDiv;
                ChCaret:  kind = TkPower;
                ChSpace:  is_tok = 1'b0;
                default: begin
                  bundle_o.res[n[SlotW-1:0]] = mk_res(TkError, pos, '0, ErrSymbol);
                  n   = n + 1'b1;
                  err = 1'b1;
                end
              endcase
              if (!err && is_tok) begin
                bundle_o.res[n[SlotW-1:0]] = mk_res(kind, pos, PosW'(1), ErrNone);
                n = n + 1'b1;
              end
            end
          end
        end
      end

      if (chars_i.expr_end && !err) begin
        if (in_num_d) begin
          bundle_o.res[n[SlotW-1:0]] =
            mk_res(TkNumber, num_start_d, pos_d - num_start_d, ErrNone);
          n        = n + 1'b1;
          in_num_d = 1'b0;
        end
        if (in_word_d) begin
          in_word_d = 1'b0;
          if (!mismatch_d && match_d == SqrtLen) begin
            bundle_o.res[n[SlotW-1:0]] =
              mk_res(TkSqrt, word_start_d, pos_d - word_start_d, ErrNone);
          end else begin
            bundle_o.res[n[SlotW-1:0]] = mk_res(TkError, word_start_d, '0, ErrIdent);
            err = 1'b1;
          end
          n = n + 1'b1;
        end
        if (!err) begin
          bundle_o.res[n[SlotW-1:0]] = mk_res(TkEnd, pos_d, '0, ErrNone);
          n    = n + 1'b1;
          done = 1'b1;
        end
      end

      if (err) begin
        if (chars_i.expr_end) begin
          done = 1'b1;
        end else begin
          discard_d = 1'b1;
        end
      end
    end

    if (done) begin
      pos_d        = '0;
      in_num_d     = 1'b0;
      num_start_d  = '0;
      in_word_d    = 1'b0;
      word_start_d = '0;
      match_d      = '0;
      mismatch_d   = 1'b0;
      discard_d    = 1'b0;
    end

    bundle_o.count = n;
  end

  assign push_o = accept && (bundle_o.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      in_num_q     <= 1'b0;
      num_start_q  <= '0;
      in_word_q    <= 1'b0;
      word_start_q <= '0;
      match_q      <= '0;
      mismatch_q   <= 1'b0;
      discard_q    <= 1'b0;
    end else if (accept) begin
      pos_q        <= pos_d;
      in_num_q     <= in_num_d;
      num_start_q  <= num_start_d;
      in_word_q    <= in_word_d;
      word_start_q <= word_start_d;
      match_q      <= match_d;
      mismatch_q   <= mismatch_d;
      discard_q    <= discard_d;
    end
  end

endmodule

>>> hw/rtl/etl_queue.sv
module etl_queue import etl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    valid_o,
  output bundle_t head_o
);

  bundle_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/etl_back.sv
module etl_back import etl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  bundle_t     head_i,
  output logic        pop_o,
  etl_token_if.source tokens_o
);

  logic [SlotW-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q;
  logic             out_last_q;
  logic             load;
  logic             last;

  assign load = !out_valid_q || tokens_o.ready;
  assign last = ({1'b0, idx_q} + 1'b1) == head_i.count;
  assign pop_o = load && valid_i && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = valid_i;
      if (valid_i) begin
        idx_d = last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      out_res_q  <= head_i.res[idx_q];
      out_last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign tokens_o.valid        = out_valid_q;
  assign tokens_o.token_kind   = out_res_q.kind;
  assign tokens_o.token_start  = out_res_q.start;
  assign tokens_o.token_length = out_res_q.length;
  assign tokens_o.error_kind   = out_res_q.err;
  assign tokens_o.last_of_item = out_last_q;

endmodule

>>> hw/rtl/expression_token_lexer.sv
// Channel    Dir  Payload                                                  Moves when
// chars_i    in   char_code[8] char_present expr_end                       valid & ready
// tokens_o   out  kind[4] start[13] length[13] error_kind[2] last_of_item  valid & ready
//
// One character enters per cycle while the queue has room; each produces zero to four tokens,
// drained one per cycle while tokens_o is ready. The front stage classifies combinationally
// and registers run state, then a 2-entry queue holds the token group until the output
// serializer emits it through a registered stage; throughput is set by token count.
// Reset is asynchronous and clears position, run and discard state; no clearing pass.
// chars_i stalls only when the queue is full; tokens_o stalls hold the output register.
module expression_token_lexer import etl_pkg::*; #(
  parameter int unsigned MaxLen = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  etl_char_if.sink    chars_i,
  etl_token_if.source tokens_o
);

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_valid;
  bundle_t q_in;
  bundle_t q_head;

  etl_front #(.MaxLen(MaxLen)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .chars_i  (chars_i),
    .full_i   (q_full),
    .push_o   (q_push),
    .bundle_o (q_in)
  );

  etl_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .bundle_i (q_in),
    .pop_i    (q_pop),
    .full_o   (q_full),
    .valid_o  (q_valid),
    .head_o   (q_head)
  );

  etl_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .head_i   (q_head),
    .pop_o    (q_pop),
    .tokens_o (tokens_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("token group pushed into full queue");

  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> (q_head.count != '0) && (q_head.count <= CntW'(MaxRes)))
    else $error("queued token group has bad count");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tokens_o.valid && tokens_o.token_kind == TkEnd) |-> tokens_o.last_of_item)
    else $error("end token not last of its transaction");

  a_err_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tokens_o.valid |-> ((tokens_o.token_kind == TkError) == (tokens_o.error_kind != ErrNone)))
    else $error("error kind does not match token kind");

endmodule
